@@ rtl/hsr_pkg.sv @@
// Shared constants, payload types and span test for the harmonic spur rejection block.
package hsr_pkg;

   localparam int MAX_TRACKS = 32;
   localparam int IDX_W      = $clog2(MAX_TRACKS);
   localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
   localparam int VAL_W      = 16;
   localparam int TIDX_W     = 5;
   localparam int SPUR_W     = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BASE_RF    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BASE_POWER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION      = 2'd2;

   localparam logic [VAL_W-1:0] MAX_BASE_RF_RST    = 16'd10000;
   localparam logic [VAL_W-1:0] MIN_BASE_POWER_RST = 16'd1900;
   localparam logic [VAL_W-1:0] DEVIATION_RST      = 16'd10;

   typedef struct packed {
      logic [VAL_W-1:0] rf_value;
      logic [VAL_W-1:0] rf_low;
      logic [VAL_W-1:0] rf_high;
      logic [VAL_W-1:0] power_x;
      logic [VAL_W-1:0] power_y;
      logic             rf_computed;
      logic             already_deleted;
      logic             last_track;
   } req_type;

   typedef struct packed {
      logic [TIDX_W-1:0] track_index;
      logic              delete_flag;
      logic [SPUR_W-1:0] spur_count;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] rf_value;
      logic [VAL_W-1:0] rf_low;
      logic [VAL_W-1:0] rf_high;
      logic [VAL_W-1:0] power;
      logic             computed;
      logic             deleted;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // True when the test span lies inside k times the base span widened by dev.
   // The test fails when k times the base low edge is below dev.
   function automatic logic span_fits(input logic [VAL_W-1:0] blo,
                                      input logic [VAL_W-1:0] bhi,
                                      input logic [VAL_W-1:0] tlo,
                                      input logic [VAL_W-1:0] thi,
                                      input logic [VAL_W-1:0] dev,
                                      input logic             k3);
      logic [VAL_W+2:0] klo;
      logic [VAL_W+2:0] khi;
      logic [VAL_W+2:0] dev_x;
      klo   = {2'b00, blo, 1'b0} + (k3 ? {3'b000, blo} : '0);
      khi   = {2'b00, bhi, 1'b0} + (k3 ? {3'b000, bhi} : '0);
      dev_x = {3'b000, dev};
      return (klo >= dev_x) && (klo < ({3'b000, tlo} + dev_x)) &&
             ({3'b000, thi} < (khi + dev_x));
   endfunction

endpackage

@@ rtl/hsr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module hsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/rf_harmonic_spur_rejection.sv @@
// Top level of the harmonic spur rejection block: track store, pair sequencer and readout.
//
//   channel | ports                          | direction | transaction
//   --------+--------------------------------+-----------+-------------------------------
//   req     | req_valid, req_ready, req_data | in        | one track; last_track starts a pass
//   rsp     | rsp_valid, rsp_ready, rsp_data | out       | one delete flag per stored track
//   csr     | csr_wr_en, csr_index, csr_wdata| in        | register write, no handshake
//
// Loading stores one track per accepted request. The pair pass handles one pair per cycle
// through the single read port of the track RAM, and the readout passes each result through
// ST_ORD and ST_OLAT. Reset is synchronous; it clears the sequencer and restores the register
// defaults, and the track RAM is not cleared. req_ready is high only while tracks are loading;
// a stalled rsp_ready holds the readout.
module rf_harmonic_spur_rejection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hsr_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hsr_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [hsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsr_pkg::VAL_W-1:0]        csr_wdata
);

   import hsr_pkg::*;

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_ROW  = 3'd1;
   localparam logic [2:0] ST_BASE = 3'd2;
   localparam logic [2:0] ST_PAIR = 3'd3;
   localparam logic [2:0] ST_ORD  = 3'd4;
   localparam logic [2:0] ST_OLAT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  o_ff, o_in;
   logic [IDX_W-1:0]  pj_ff, pj_in;
   logic              pend_ff, pend_in;
   logic [SPUR_W-1:0] spur_ff, spur_in;
   entry_type         base_ff, base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [VAL_W-1:0]  max_rf_ff, min_pow_ff, dev_ff;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   entry_type         ram_rdata;

   logic [CNT_W-1:0]  i_next, o_next;
   logic              i_is_base;
   entry_type         pair_base, pair_test;
   logic              pair_spur;

   hsr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TRACKS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign i_next    = i_ff + 1'b1;
   assign o_next    = o_ff + 1'b1;
   assign i_is_base = base_ff.rf_value < ram_rdata.rf_value;
   assign pair_base = i_is_base ? base_ff : ram_rdata;
   assign pair_test = i_is_base ? ram_rdata : base_ff;

   assign pair_spur = pend_ff && !ram_rdata.deleted &&
                      (pair_base.rf_value <= max_rf_ff) &&
                      (pair_base.power >= min_pow_ff) &&
                      base_ff.computed && ram_rdata.computed &&
                      (span_fits(pair_base.rf_low, pair_base.rf_high, pair_test.rf_low,
                                 pair_test.rf_high, dev_ff, 1'b0) ||
                       span_fits(pair_base.rf_low, pair_base.rf_high, pair_test.rf_low,
                                 pair_test.rf_high, dev_ff, 1'b1));

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      o_in         = o_ff;
      pj_in        = pj_ff;
      pend_in      = 1'b0;
      spur_in      = spur_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_TRACKS)) begin
                  ram_we             = 1'b1;
                  ram_waddr          = count_ff[IDX_W-1:0];
                  ram_wdata.rf_value = req_data.rf_value;
                  ram_wdata.rf_low   = req_data.rf_low;
                  ram_wdata.rf_high  = req_data.rf_high;
                  ram_wdata.power    = (req_data.power_x > req_data.power_y) ?
                                       req_data.power_x : req_data.power_y;
                  ram_wdata.computed = req_data.rf_computed;
                  ram_wdata.deleted  = req_data.already_deleted;
                  count_in           = count_ff + 1'b1;
               end
               if (req_data.last_track) begin
                  i_in     = '0;
                  spur_in  = '0;
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            ram_re    = 1'b1;
            ram_raddr = i_ff[IDX_W-1:0];
            state_in  = ST_BASE;
         end
         ST_BASE: begin
            base_in = ram_rdata;
            o_in    = '0;
            if (ram_rdata.deleted || (i_next >= count_ff)) begin
               i_in     = i_next;
               state_in = (i_next >= count_ff) ? ST_ORD : ST_ROW;
            end else begin
               j_in     = i_next;
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (j_ff < count_ff) begin
               ram_re    = 1'b1;
               ram_raddr = j_ff[IDX_W-1:0];
               pend_in   = 1'b1;
               pj_in     = j_ff[IDX_W-1:0];
               j_in      = j_ff + 1'b1;
            end
            if (pair_spur) begin
               ram_we = 1'b1;
               if (spur_ff != '1) begin
                  spur_in = spur_ff + 1'b1;
               end
               if (i_is_base) begin
                  ram_waddr         = pj_ff;
                  ram_wdata         = ram_rdata;
                  ram_wdata.deleted = 1'b1;
               end else begin
                  ram_waddr         = i_ff[IDX_W-1:0];
                  ram_wdata         = base_ff;
                  ram_wdata.deleted = 1'b1;
               end
            end
            if (!(j_ff < count_ff) && !pend_ff) begin
               i_in     = i_next;
               o_in     = '0;
               state_in = (i_next >= count_ff) ? ST_ORD : ST_ROW;
            end
         end
         ST_ORD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ram_re    = 1'b1;
               ram_raddr = o_ff[IDX_W-1:0];
               state_in  = ST_OLAT;
            end
         end
         ST_OLAT: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.track_index = TIDX_W'(o_ff);
            rsp_data_in.delete_flag = ram_rdata.deleted;
            rsp_data_in.spur_count  = spur_ff;
            rsp_data_in.last_result = (o_next == count_ff);
            o_in                    = o_next;
            if (o_next >= count_ff) begin
               count_in = '0;
               spur_in  = '0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_ORD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         o_ff         <= '0;
         pend_ff      <= 1'b0;
         spur_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         o_ff         <= o_in;
         pend_ff      <= pend_in;
         spur_ff      <= spur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pj_ff       <= pj_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rf_ff  <= MAX_BASE_RF_RST;
         min_pow_ff <= MIN_BASE_POWER_RST;
         dev_ff     <= DEVIATION_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_BASE_RF:    max_rf_ff  <= csr_wdata;
            CSR_MIN_BASE_POWER: min_pow_ff <= csr_wdata;
            CSR_DEVIATION:      dev_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/hsr_checker.sv @@
// Port-level checker for the harmonic spur rejection block and its bind statement.
module hsr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input hsr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hsr_pkg::rsp_type rsp_data
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // The output register comes out of reset empty.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A last track starts the pair pass, so loading stops at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_track |=> !req_ready)
      else $error("req_ready high after the last track");

   // Loading never resumes while results of the set are still to come.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_result |=> !req_ready)
      else $error("req_ready high during readout");

   // A result transaction never coincides with loading unless it is the final one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_ready |-> rsp_data.last_result)
      else $error("loading while readout is unfinished");

endmodule

bind rf_harmonic_spur_rejection hsr_checker u_hsr_checker (.*);
